>>> rtl/core/rwz_pkg.sv
// rwz_pkg: widths, limits and register map of the rolling window z-score block
// no dependencies
`default_nettype none
package rwz_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 256;
  localparam int unsigned CFG_W          = 9;
  localparam int unsigned SAMPLE_W       = 24;
  localparam int unsigned ZS_W           = 20;
  localparam int unsigned SUM_W          = 32;
  localparam int unsigned SQS_W          = 56;
  localparam int unsigned RAD_W          = 64;
  localparam int unsigned ROOT_W         = 32;
  localparam int unsigned NUM_W          = 45;
  localparam int unsigned ADDR_W         = 3;

  localparam logic [CFG_W-1:0]  WIN_RESET = CFG_W'(20);
  localparam logic              REG_WINDOW = 1'b0;

  localparam logic [NUM_W-1:0]  ZS_POS_LIM = NUM_W'(524287);
  localparam logic [NUM_W-1:0]  ZS_NEG_LIM = NUM_W'(524288);
  localparam logic [ZS_W-1:0]   ZS_MAX     = 20'h7FFFF;
  localparam logic [ZS_W-1:0]   ZS_MIN     = 20'h80000;

endpackage
`default_nettype wire

>>> rtl/core/rwz_ring.sv
// rwz_ring: history ring of past samples, one write and one registered read port
// depends on rwz_pkg
`default_nettype none
module rwz_ring #(
  parameter int unsigned DEPTH = rwz_pkg::MAX_WINDOW_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [AW-1:0]                 waddr_i,
  input  wire logic [rwz_pkg::SAMPLE_W-1:0]  wdata_i,
  input  wire logic                          re_i,
  input  wire logic [AW-1:0]                 raddr_i,
  output logic      [rwz_pkg::SAMPLE_W-1:0]  rdata_o
);
  import rwz_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/core/rwz_sqrt.sv
// rwz_sqrt: floored integer square root, two radicand bits per cycle
// depends on rwz_pkg
`default_nettype none
module rwz_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rwz_pkg::RAD_W-1:0]   rad_i,
  output logic                             done_o,
  output logic      [rwz_pkg::ROOT_W-1:0]  root_o
);
  import rwz_pkg::*;

  localparam int unsigned STEPS = RAD_W / 2;
  localparam int unsigned CW    = $clog2(STEPS);

  logic [RAD_W-1:0] x_q, x_d, r_q, r_d, b_q, b_d, trial;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  always_comb begin
    trial  = r_q + b_q;
    x_d    = x_q;
    r_d    = r_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = rad_i;
      r_d    = '0;
      b_d    = RAD_W'(1) << (RAD_W - 2);
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_d = x_q - trial;
        r_d = (r_q >> 1) + b_q;
      end else begin
        r_d = r_q >> 1;
      end
      b_d   = b_q >> 2;
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    r_q <= r_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[ROOT_W-1:0];

endmodule
`default_nettype wire

>>> rtl/core/rwz_div.sv
// rwz_div: restoring divider of magnitudes, one quotient bit per cycle
// depends on rwz_pkg
`default_nettype none
module rwz_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rwz_pkg::NUM_W-1:0]   num_i,
  input  wire logic [rwz_pkg::ROOT_W-1:0]  den_i,
  output logic                             done_o,
  output logic      [rwz_pkg::NUM_W-1:0]   quo_o
);
  import rwz_pkg::*;

  localparam int unsigned CW = $clog2(NUM_W);

  logic [ROOT_W:0]   rem_q, rem_d, sh;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [ROOT_W-1:0] den_q, den_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  always_comb begin
    sh     = {rem_q[ROOT_W-1:0], quo_q[NUM_W-1]};
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

>>> rtl/core/rolling_window_zscore.sv
// rolling_window_zscore: top level, sequencer, running sums and apb register
// depends on rwz_pkg, rwz_ring, rwz_sqrt, rwz_div
`default_nettype none
// Scores each spread sample against the window of W preceding samples (W from the
// window_length register, 0 taken as 1, values above MAX_WINDOW taken as MAX_WINDOW)
// and returns a Q7.12 z-score with warm, flat and saturated flags. One sample is in
// flight at a time. A warm, non-flat sample passes through the ring read and products,
// the 32-step square root and its hand-off, the 45-step divider and its hand-off, and
// the loading of the result register. Cold samples, and samples found flat before the
// root, skip the root and the divider; a zero root skips the divider. The next sample
// is accepted the cycle after the result register is loaded; a result beat still
// waiting holds the next sample in its last cycle. Writing window_length clears the
// running sums and restarts warm-up; the ring needs no clearing pass.
module rolling_window_zscore #(
  parameter int unsigned MAX_WINDOW = rwz_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  spread_sample_valid_i,
  output logic                                       spread_sample_ready_o,
  input  wire logic signed [rwz_pkg::SAMPLE_W-1:0]   spread_sample_i,
  output logic                                       result_valid_o,
  input  wire logic                                  result_ready_i,
  output logic signed      [rwz_pkg::ZS_W-1:0]       zscore_o,
  output logic                                       warm_o,
  output logic                                       flat_o,
  output logic                                       saturated_o,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic        [rwz_pkg::ADDR_W-1:0]     paddr,
  input  wire logic        [31:0]                    pwdata,
  output logic             [31:0]                    prdata,
  output logic                                       pready
);
  import rwz_pkg::*;

  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned WW = $clog2(MAX_WINDOW + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_PREP, ST_SQRT, ST_DIV, ST_FIN
  } state_e;

  state_e                state_q;
  logic [CFG_W-1:0]      win_q;
  logic [AW-1:0]         wp_q;
  logic [WW-1:0]         seen_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SQS_W-1:0]      sqs_q;
  logic                  out_valid_q;

  logic signed [SAMPLE_W-1:0] s_q, old_q;
  logic [AW-1:0]         pos_q;
  logic                  warm_q, flat_q, neg_q;
  logic [RAD_W-1:0]      wq_q, ss_q;
  logic signed [WW+SAMPLE_W:0] ws_q;
  logic [2*SAMPLE_W-1:0] ssq_q, osq_q;
  logic [NUM_W-1:0]      num_q;
  logic signed [ZS_W-1:0] zs_q;
  logic                  zsat_q;
  logic signed [ZS_W-1:0] res_zs_q;
  logic                  res_warm_q, res_flat_q, res_sat_q;

  logic [WW-1:0]         w_eff, wp_nxt;
  logic                  in_acc, cfg_we, fin_go, sqrt_start, sqrt_done, div_start, div_done;
  logic [SUM_W-1:0]      sum_mag;
  logic [SAMPLE_W-1:0]   rd_data;
  logic [ROOT_W-1:0]     root_w;
  logic [NUM_W-1:0]      quo_w;
  logic signed [WW+SAMPLE_W+1:0] nd;
  logic [WW+SAMPLE_W+1:0] nd_mag;
  logic [ZS_W-1:0]       z_val;
  logic                  z_sat;

  always_comb begin
    if (win_q == '0) begin
      w_eff = WW'(1);
    end else if (win_q > CFG_W'(MAX_WINDOW)) begin
      w_eff = WW'(MAX_WINDOW);
    end else begin
      w_eff = win_q[WW-1:0];
    end
  end

  assign in_acc  = spread_sample_valid_i && spread_sample_ready_o;
  assign cfg_we  = psel && penable && pwrite && (paddr[2] == REG_WINDOW);
  assign fin_go  = (state_q == ST_FIN) && (!out_valid_q || result_ready_i);
  assign wp_nxt  = WW'(pos_q) + WW'(1);
  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign nd      = ws_q - sum_q;
  assign nd_mag  = nd[WW+SAMPLE_W+1] ? (WW+SAMPLE_W+2)'(-nd) : (WW+SAMPLE_W+2)'(nd);
  assign sqrt_start = (state_q == ST_PREP) && warm_q && (wq_q > ss_q);
  assign div_start  = (state_q == ST_SQRT) && sqrt_done && (root_w != '0);

  rwz_ring #(.DEPTH(MAX_WINDOW), .AW(AW)) u_ring (
    .clk_i   (clk_i),
    .we_i    (fin_go),
    .waddr_i (pos_q),
    .wdata_i (s_q),
    .re_i    (in_acc),
    .raddr_i (wp_q),
    .rdata_o (rd_data)
  );

  rwz_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (wq_q - ss_q),
    .done_o  (sqrt_done),
    .root_o  (root_w)
  );

  rwz_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (root_w),
    .done_o  (div_done),
    .quo_o   (quo_w)
  );

  always_comb begin
    z_sat = 1'b0;
    z_val = quo_w[ZS_W-1:0];
    if (!neg_q) begin
      if (quo_w > ZS_POS_LIM) begin
        z_sat = 1'b1;
        z_val = ZS_MAX;
      end
    end else begin
      if (quo_w > ZS_NEG_LIM) begin
        z_sat = 1'b1;
        z_val = ZS_MIN;
      end else begin
        z_val = ZS_W'(-quo_w);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= WIN_RESET;
      wp_q        <= '0;
      seen_q      <= '0;
      sum_q       <= '0;
      sqs_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && result_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we) begin
        win_q  <= pwdata[CFG_W-1:0];
        wp_q   <= '0;
        seen_q <= '0;
        sum_q  <= '0;
        sqs_q  <= '0;
      end else if (fin_go) begin
        wp_q <= (wp_nxt == w_eff) ? '0 : AW'(wp_nxt);
        if (warm_q) begin
          sum_q <= sum_q - SUM_W'(old_q) + SUM_W'(s_q);
          sqs_q <= sqs_q - SQS_W'(osq_q) + SQS_W'(ssq_q);
        end else begin
          seen_q <= seen_q + WW'(1);
          sum_q  <= sum_q + SUM_W'(s_q);
          sqs_q  <= sqs_q + SQS_W'(ssq_q);
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL:  state_q <= ST_PREP;
        ST_PREP: state_q <= sqrt_start ? ST_SQRT : ST_FIN;
        ST_SQRT: begin
          if (sqrt_done) begin
            state_q <= div_start ? ST_DIV : ST_FIN;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_q    <= spread_sample_i;
      pos_q  <= wp_q;
      warm_q <= (seen_q >= w_eff);
    end
    if (state_q == ST_MUL) begin
      old_q <= rd_data;
      wq_q  <= RAD_W'(w_eff * sqs_q);
      ss_q  <= RAD_W'(sum_mag * sum_mag);
      ws_q  <= $signed({1'b0, w_eff}) * s_q;
      ssq_q <= (2*SAMPLE_W)'(s_q * s_q);
    end
    if (state_q == ST_PREP) begin
      osq_q  <= (2*SAMPLE_W)'(old_q * old_q);
      num_q  <= NUM_W'({nd_mag, 12'b0});
      neg_q  <= nd[WW+SAMPLE_W+1];
      flat_q <= !(wq_q > ss_q);
    end
    if (state_q == ST_SQRT && sqrt_done) begin
      if (root_w == '0) begin
        flat_q <= 1'b1;
      end
    end
    if (state_q == ST_PREP) begin
      zs_q  <= '0;
      zsat_q <= 1'b0;
    end
    if (state_q == ST_DIV && div_done) begin
      zs_q   <= z_val;
      zsat_q <= z_sat;
    end
    if (fin_go) begin
      res_zs_q   <= zs_q;
      res_warm_q <= warm_q;
      res_flat_q <= warm_q && flat_q;
      res_sat_q  <= zsat_q;
    end
  end

  assign zscore_o    = res_zs_q;
  assign warm_o      = res_warm_q;
  assign flat_o      = res_flat_q;
  assign saturated_o = res_sat_q;

  assign spread_sample_ready_o = (state_q == ST_IDLE);
  assign result_valid_o = out_valid_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW) ? {{(32-CFG_W){1'b0}}, win_q} : 32'd0;

endmodule
`default_nettype wire
